// ===== sv/cel_pkg.sv =====
// shared types and constants for the circular event log
package cel_pkg;

  // log geometry
  localparam int LOG_DEPTH   = 16;
  localparam int RECORD_BITS = 64;
  localparam int IDX_W       = $clog2(LOG_DEPTH);
  localparam int CNT_W       = $clog2(LOG_DEPTH + 1);
  localparam int PTR_W       = CNT_W + 1;

  // fixed field widths of the item interface
  localparam int DATA_W      = 64;
  localparam int OUT_CNT_W   = 5;
  localparam int OVF_W       = 16;
  localparam logic [OVF_W-1:0] OVF_MAX = '1;

  // action codes
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_DUMP  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [DATA_W-1:0] record_data;
  } in_item_t;

  typedef struct packed {
    logic                 record_valid;
    logic [DATA_W-1:0]    record_out;
    logic                 last;
    logic [OUT_CNT_W-1:0] stored_count;
    logic                 full_seen;
    logic [OVF_W-1:0]     overflow_total;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic status_issue;
    logic dump_start;
    logic dump_read;
  } cel_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic final_read;
  } cel_stat_t;

endpackage

// ===== sv/circular_event_log_unit.sv =====
// circular event log top level: add, clear and dump of a ring of event records
// add, clear or an empty dump: one result in the cycle after the transfer; a new item each cycle when not busy
// dump of n records: busy while they are read, one record a cycle from the single memory read port,
// first record after the state register and then the record register, last flagged; next item taken as the last shows
// results cannot be stalled: each is on the ports for one cycle with out_strobe
// reset clears index, count, full flag, overflow counter and mode; record memory is not cleared
module circular_event_log_unit import cel_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output logic      out_strobe,
  output out_item_t out_item
);

  cel_cmd_t  cmd;
  cel_stat_t stat;

  // sequencing of items and dumps
  cel_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_item.action),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  // storage, counters and result register
  cel_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== sv/cel_ctrl.sv =====
// controller state machine for the circular event log
module cel_ctrl import cel_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] action,
  input  cel_stat_t  stat,
  output logic       busy,
  output cel_cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  logic   dump_go;

  // input transfer and dump launch
  assign busy    = (state_r == ST_DUMP);
  assign accept  = start && !busy;
  assign dump_go = accept && (action == ACT_DUMP) && !stat.empty;

  // commands
  always_comb begin
    cmd.status_issue = accept && !dump_go;
    cmd.dump_start   = dump_go;
    cmd.dump_read    = (state_r == ST_DUMP);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (dump_go) state_nxt = ST_DUMP;
      end
      ST_DUMP: begin
        if (stat.final_read) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/cel_dpath.sv =====
// datapath of the circular event log: record memory, counters, result register
module cel_dpath import cel_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  cel_cmd_t  cmd,
  output cel_stat_t stat,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic [RECORD_BITS-1:0] mem [LOG_DEPTH];

  logic             mode_r;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full_r, full_nxt;
  logic [OVF_W-1:0] ovf_r, ovf_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;

  logic                   strobe_r;
  logic [RECORD_BITS-1:0] rec_r;
  logic                   rec_valid_r;
  logic                   last_r;
  logic [CNT_W-1:0]       out_cnt_r;
  logic                   out_full_r;
  logic [OVF_W-1:0]       out_ovf_r;

  logic             is_full;
  logic             mem_we;
  logic [PTR_W-1:0] ptr_sum;
  logic [IDX_W-1:0] ptr_start;

  assign stat.empty      = (cnt_r == '0);
  assign stat.final_read = (rem_r == CNT_W'(1));
  assign is_full         = (cnt_r == CNT_W'(LOG_DEPTH));

  // oldest record position: write index minus count, modulo depth
  assign ptr_sum   = PTR_W'(wr_idx_r) + PTR_W'(LOG_DEPTH) - PTR_W'(cnt_r);
  assign ptr_start = (ptr_sum >= PTR_W'(LOG_DEPTH)) ? IDX_W'(ptr_sum - PTR_W'(LOG_DEPTH))
                                                   : IDX_W'(ptr_sum);

  // log state update per accepted item
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    cnt_nxt    = cnt_r;
    full_nxt   = full_r;
    ovf_nxt    = ovf_r;
    mem_we     = 1'b0;
    if (cmd.status_issue) begin
      case (in_item.action)
        ACT_ADD: begin
          if (is_full && ovf_r != OVF_MAX) ovf_nxt = ovf_r + OVF_W'(1);
          if (!(is_full && mode_r)) begin
            mem_we     = 1'b1;
            wr_idx_nxt = (wr_idx_r == IDX_W'(LOG_DEPTH - 1)) ? '0 : wr_idx_r + IDX_W'(1);
            if (!is_full) cnt_nxt = cnt_r + CNT_W'(1);
            if (cnt_nxt == CNT_W'(LOG_DEPTH)) full_nxt = 1'b1;
          end
        end
        ACT_CLEAR: begin
          wr_idx_nxt = '0;
          cnt_nxt    = '0;
          full_nxt   = 1'b0;
          ovf_nxt    = '0;
        end
        default: ;
      endcase
    end
  end

  // dump read pointer and remaining count
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    rem_nxt    = rem_r;
    if (cmd.dump_start) begin
      rd_ptr_nxt = ptr_start;
      rem_nxt    = cnt_r;
    end else if (cmd.dump_read) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(LOG_DEPTH - 1)) ? '0 : rd_ptr_r + IDX_W'(1);
      rem_nxt    = rem_r - CNT_W'(1);
    end
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      wr_idx_r <= '0;
      cnt_r    <= '0;
      full_r   <= 1'b0;
      ovf_r    <= '0;
      rd_ptr_r <= '0;
      rem_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      wr_idx_r <= wr_idx_nxt;
      cnt_r    <= cnt_nxt;
      full_r   <= full_nxt;
      ovf_r    <= ovf_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      rem_r    <= rem_nxt;
      strobe_r <= cmd.status_issue || cmd.dump_read;
    end
  end

  // record memory with registered read into the result register
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx_r] <= in_item.record_data[RECORD_BITS-1:0];
    if (cmd.dump_read) begin
      rec_r <= mem[rd_ptr_r];
    end else if (cmd.status_issue) begin
      rec_r <= '0;
    end
  end

  // result fields, status taken after the step
  always_ff @(posedge clk) begin
    if (cmd.status_issue || cmd.dump_read) begin
      rec_valid_r <= cmd.dump_read;
      last_r      <= cmd.status_issue || stat.final_read;
      out_cnt_r   <= cnt_nxt;
      out_full_r  <= full_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_strobe              = strobe_r;
  assign out_item.record_valid   = rec_valid_r;
  assign out_item.record_out     = DATA_W'(rec_r);
  assign out_item.last           = last_r;
  assign out_item.stored_count   = OUT_CNT_W'(out_cnt_r);
  assign out_item.full_seen      = out_full_r;
  assign out_item.overflow_total = out_ovf_r;

endmodule
